// File: src/checked_frame_verifier_macros.svh
// assertion macros shared by the record checker rtl
`ifndef CHECKED_FRAME_VERIFIER_MACROS_SVH
`define CHECKED_FRAME_VERIFIER_MACROS_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define CFV_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define CFV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/cfv_pkg.sv
// types, constants and hash helper for the record checker
package cfv_pkg;

    localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;
    localparam logic [63:0] HDR_BYTES = 64'd16;
    localparam logic [63:0] MIN_BYTES = 64'd24;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_TRUNC    = 3'd1;
    localparam logic [2:0] ST_UNSUP    = 3'd2;
    localparam logic [2:0] ST_TRAIL    = 3'd3;
    localparam logic [2:0] ST_MISMATCH = 3'd4;

    localparam logic [0:0] REG_EXP_VERSION = 1'b0;

    typedef struct packed {
        logic       valid;
        logic [7:0] data_byte;
        logic       last_byte;
    } t_step;

    typedef struct packed {
        logic [63:0] sum_calc;
        logic [63:0] sum_found;
        logic [63:0] declared_length;
        logic [2:0]  status;
    } t_result;

    // "TCKP" magic, byte by byte
    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] m;
        case (idx)
            2'd0:    m = 8'h54;
            2'd1:    m = 8'h43;
            2'd2:    m = 8'h4B;
            default: m = 8'h50;
        endcase
        return m;
    endfunction

    // one fnv-1a round: xor, then multiply by 2^40 + 0x1b3 as shift-adds
    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

endpackage

// File: src/cfv_frame_core.sv
// per-record state: byte count, running hash, captured words, final status
module cfv_frame_core
    import cfv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_step       i_step,
    input  logic [31:0] i_expected_version,
    output t_result     o_result
);

    logic [63:0] r_count,   n_count;
    logic [63:0] r_hash,    n_hash;
    logic        r_magic,   n_magic;
    logic [31:0] r_version, n_version;
    logic [63:0] r_length,  n_length;
    logic [63:0] r_chk,     n_chk;

    logic [63:0] body_off;
    logic [63:0] chk_off;
    logic        in_hdr;
    logic        hashed;
    logic        n_ge24;
    logic [63:0] n_m24;
    logic        len_fits;
    logic        full;

    always_comb begin
        n_magic   = r_magic;
        n_version = r_version;
        n_length  = r_length;
        n_chk     = r_chk;
        in_hdr    = (r_count[63:4] == 60'd0);
        body_off  = r_count - HDR_BYTES;
        chk_off   = body_off - r_length;

        if (r_count[63:2] == 62'd0) begin
            if (i_step.data_byte != magic_byte(r_count[1:0])) begin
                n_magic = 1'b0;
            end
        end
        if (r_count[63:3] == 61'd0 && r_count[2]) begin
            n_version[{r_count[1:0], 3'b000} +: 8] = i_step.data_byte;
        end
        if (in_hdr && r_count[3]) begin
            n_length[{r_count[2:0], 3'b000} +: 8] = i_step.data_byte;
        end

        hashed = in_hdr || (body_off < r_length);
        if (!hashed && chk_off[63:3] == 61'd0) begin
            n_chk[{chk_off[2:0], 3'b000} +: 8] =
                r_chk[{chk_off[2:0], 3'b000} +: 8] | i_step.data_byte;
        end
        n_hash  = hashed ? fnv_step(r_hash, i_step.data_byte) : r_hash;
        n_count = (&r_count) ? r_count : r_count + 64'd1;

        // status from the state as it stands after this byte
        n_ge24   = (n_count >= MIN_BYTES);
        n_m24    = n_count - MIN_BYTES;
        len_fits = (n_length <= n_m24);
        full     = n_ge24 && len_fits;

        if (!n_ge24) begin
            o_result.status = ST_TRUNC;
        end else if (!n_magic || n_version != i_expected_version) begin
            o_result.status = ST_UNSUP;
        end else if (!len_fits) begin
            o_result.status = ST_TRUNC;
        end else if (n_m24 != n_length) begin
            o_result.status = ST_TRAIL;
        end else if (n_chk != n_hash) begin
            o_result.status = ST_MISMATCH;
        end else begin
            o_result.status = ST_OK;
        end
        o_result.declared_length = (n_count >= HDR_BYTES) ? n_length : 64'd0;
        o_result.sum_found       = full ? n_chk : 64'd0;
        o_result.sum_calc        = full ? n_hash : 64'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step.valid && i_step.last_byte)) begin
            r_count   <= 64'd0;
            r_hash    <= FNV_BASIS;
            r_magic   <= 1'b1;
            r_version <= 32'd0;
            r_length  <= 64'd0;
            r_chk     <= 64'd0;
        end else if (i_step.valid) begin
            r_count   <= n_count;
            r_hash    <= n_hash;
            r_magic   <= n_magic;
            r_version <= n_version;
            r_length  <= n_length;
            r_chk     <= n_chk;
        end
    end

endmodule

// File: src/checked_frame_verifier.sv
// top level: byte-stream record checker with fnv-1a 64 checksum and apb config
// the last byte passes the input register, then the result register, before a result is valid
// throughput: one byte per cycle while no closing byte is held, set by the combinational hash round on r_hash
// only the final byte of a record waits when the result register is still full
// reset (synchronous, active low) clears record state, empties both stages,
// and sets expected_version to 1
module checked_frame_verifier
    import cfv_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    // byte stream in
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [7:0]   i_s_axis_tdata,   // [7:0] data_byte
    input  logic         i_s_axis_tlast,   // last_byte
    // result stream out
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [199:0] o_m_axis_tdata,   // [2:0] status, [66:3] declared_length,
                                           // [130:67] checksum found after the body,
                                           // [194:131] checksum computed, rest zero
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

`include "checked_frame_verifier_macros.svh"

    // configuration register
    logic [31:0] r_exp_version;

    // input register stage
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;

    // result register stage
    logic        r_out_valid;
    t_result     r_out;

    logic        out_free;
    logic        advance;
    logic        s_xfer;
    t_step       step;
    t_result     core_result;

    // a byte in the input stage moves on unless it closes a record and the
    // result register is still holding an untaken result
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign advance  = r_in_valid && (!r_in_last || out_free);

    assign o_s_axis_tready = !r_in_valid || advance;
    assign s_xfer          = i_s_axis_tvalid && o_s_axis_tready;

    assign step.valid     = advance;
    assign step.data_byte = r_in_byte;
    assign step.last_byte = r_in_last;

    cfv_frame_core u_core (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_step             (step),
        .i_expected_version (r_exp_version),
        .o_result           (core_result)
    );

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    // result stage: loaded only by the closing byte of a record
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out <= core_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'd0, r_out.sum_calc, r_out.sum_found,
                              r_out.declared_length, r_out.status};

    // apb register file: one register, writes elsewhere are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_version <= 32'd1;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_EXP_VERSION) begin
            r_exp_version <= pwdata;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_EXP_VERSION) ? r_exp_version : 32'd0;

    // checks
    `CFV_ASSERT_NEXT(a_in_hold, r_in_valid && !advance, r_in_valid && $stable(r_in_byte) && $stable(r_in_last), "input stage lost a byte while stalled")
    `CFV_ASSERT_NEXT(a_last_to_out, advance && r_in_last, r_out_valid, "closing byte did not load the result register")
    `CFV_ASSERT_SAME(a_ok_match, r_out_valid && r_out.status == ST_OK, r_out.sum_found == r_out.sum_calc, "ok status with differing checksums")
    `CFV_ASSERT_SAME(a_ready_busy, !o_s_axis_tready, r_in_valid && r_in_last && r_out_valid, "input stalled without a blocked closing byte")

endmodule
